// ===== design/mst_pkg.sv =====
// Shared types, event codes and sizes for the multitouch slot tracker.
// No dependencies; every other design file but mst_ram refers to it by scoped names.
`default_nettype none
package mst_pkg;

	// Number of contact slots built into the slot store.
	localparam int MAX_CONTACTS = 16;
	localparam int SLOT_W = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;
	localparam int CNT_W = $clog2(MAX_CONTACTS + 1);

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// Event types and codes that the tracker reacts to.
	localparam logic [4:0] TYPE_KEY = 5'd1;
	localparam logic [4:0] TYPE_ABS = 5'd3;
	localparam logic [9:0] AX_X = 10'd0;
	localparam logic [9:0] AX_Y = 10'd1;
	localparam logic [9:0] AX_PRESSURE = 10'd24;
	localparam logic [9:0] AX_MT_SLOT = 10'd47;
	localparam logic [9:0] AX_MT_X = 10'd53;
	localparam logic [9:0] AX_MT_Y = 10'd54;
	localparam logic [9:0] AX_MT_ID = 10'd57;
	localparam logic [9:0] AX_MT_PRESSURE = 10'd58;
	localparam logic [9:0] KEY_TOUCH = 10'd330;

	// Configuration register indexes.
	localparam logic [1:0] REG_MULTI_SLOT_MODE = 2'd0;
	localparam logic [1:0] REG_SLOTS_IN_USE = 2'd1;

	// One input event.
	typedef struct packed {
		logic [4:0] event_type;
		logic [9:0] event_code;
		logic signed [31:0] event_value;
	} ev_t;

	// State update decoded from one event.
	typedef struct packed {
		logic wr_x;
		logic wr_y;
		slot_t pos_slot;
		logic act_wr;
		slot_t act_slot;
		logic act_val;
		logic clr_all;
		logic sel_wr;
		slot_t sel_slot;
	} upd_t;

endpackage
`default_nettype wire

// ===== design/mst_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; used by the tracker for the x and y coordinate stores.
`default_nettype none
module mst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input wire logic clk,
	input wire logic wr_en,
	input wire logic [AW-1:0] wr_addr,
	input wire logic [WIDTH-1:0] wr_data,
	input wire logic rd_en,
	input wire logic [AW-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port with registered read data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== design/mst_decode.sv =====
// Decodes one touch event into a slot store update command.
// Depends on mst_pkg for event codes and the update struct.
`default_nettype none
module mst_decode (
	input wire mst_pkg::ev_t ev,
	input wire logic multi,
	input wire mst_pkg::cnt_t count,
	input wire mst_pkg::slot_t slot_index,
	output mst_pkg::upd_t upd
);

	logic neg;
	logic zero;
	logic in_range;

	assign neg = ev.event_value[31];
	assign zero = (ev.event_value == 32'sd0);
	assign in_range = ($unsigned(ev.event_value) <
		{{(32 - mst_pkg::CNT_W){1'b0}}, count});

	// Event decode, following the priority of the axis codes.
	always_comb begin
		upd = '0;
		if (ev.event_type == mst_pkg::TYPE_ABS) begin
			if (ev.event_code == mst_pkg::AX_MT_SLOT && multi) begin
				if (!neg && in_range) begin
					upd.sel_wr = 1'b1;
					upd.sel_slot = mst_pkg::slot_t'(ev.event_value);
				end
			end else if (ev.event_code == mst_pkg::AX_X) begin
				upd.wr_x = 1'b1;
			end else if (ev.event_code == mst_pkg::AX_Y) begin
				upd.wr_y = 1'b1;
			end else if (ev.event_code == mst_pkg::AX_MT_X) begin
				upd.wr_x = 1'b1;
				upd.pos_slot = slot_index;
			end else if (ev.event_code == mst_pkg::AX_MT_Y) begin
				upd.wr_y = 1'b1;
				upd.pos_slot = slot_index;
			end else if (ev.event_code == mst_pkg::AX_MT_ID) begin
				upd.act_wr = 1'b1;
				upd.act_slot = slot_index;
				upd.act_val = !neg;
			end else if (ev.event_code == mst_pkg::AX_PRESSURE && !multi) begin
				upd.act_wr = 1'b1;
				upd.act_val = !neg && !zero;
			end else if (ev.event_code == mst_pkg::AX_MT_PRESSURE && multi) begin
				upd.act_wr = zero;
				upd.act_slot = slot_index;
			end
		end
		// Touch button: release clears all tracked slots in multi-slot mode; otherwise it sets slot 0 from the press.
		if (ev.event_type == mst_pkg::TYPE_KEY && ev.event_code == mst_pkg::KEY_TOUCH) begin
			if (multi) begin
				upd.clr_all = zero;
			end else begin
				upd.act_wr = 1'b1;
				upd.act_val = !neg && !zero;
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/mst_scan.sv =====
// Priority encoder that finds the first active slot below the tracked count.
// Depends on mst_pkg for slot sizes.
`default_nettype none
module mst_scan (
	input wire logic [mst_pkg::MAX_CONTACTS-1:0] active,
	input wire mst_pkg::cnt_t count,
	output logic found,
	output mst_pkg::slot_t index
);

	// Walk from the top down so the lowest active slot wins.
	always_comb begin
		found = 1'b0;
		index = '0;
		for (int i = mst_pkg::MAX_CONTACTS - 1; i >= 0; i--) begin
			if (active[i] && (mst_pkg::cnt_t'(i) < count)) begin
				found = 1'b1;
				index = mst_pkg::slot_t'(i);
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/multitouch_slot_tracker.sv =====
// Top level of the multitouch slot tracker: sequencer, active flags, x/y stores.
// Depends on mst_pkg, mst_ram, mst_decode and mst_scan.
//
//  channel  direction  handshake            payload
//  s_*      in         s_tvalid / s_tready  s_tdata: event_type, event_code, event_value
//  m_*      out        m_tvalid / m_tready  m_tdata: pressed, report_x, report_y
//  cfg_*    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each item passes through four steps: accept, update of the slot store, scan and read of
// the coordinate RAMs, and loading of the output register; the registered read of the RAMs,
// which follows the write, sets these steps. The next item is accepted only in the idle step.
// Reset clears the active flags and the RAM valid bits at once, so no clearing pass.
// A waiting result holds in the output register while the next item is accepted;
// a further result waits in the last step until that register is free.
`default_nettype none
module multitouch_slot_tracker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// [4:0] event_type, [14:5] event_code, [46:15] event_value, [47] zero
	input wire logic [47:0] s_tdata,
	output logic m_tvalid,
	input wire logic m_tready,
	// [0] pressed, [32:1] report_x, [64:33] report_y, [71:65] zero
	output logic [71:0] m_tdata,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [1:0] cfg_index,
	input wire logic [4:0] cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;
	localparam logic [1:0] ST_RESP = 2'd3;

	logic [1:0] state_q;
	logic multi_q;
	logic [4:0] slots_q;
	mst_pkg::cnt_t count;
	mst_pkg::ev_t ev_q;
	mst_pkg::upd_t upd;
	mst_pkg::slot_t slot_index_q;
	logic [mst_pkg::MAX_CONTACTS-1:0] active_q;
	logic [mst_pkg::MAX_CONTACTS-1:0] x_vld_q;
	logic [mst_pkg::MAX_CONTACTS-1:0] y_vld_q;
	logic scan_found;
	mst_pkg::slot_t scan_index;
	logic found_s2;
	logic x_vld_s2;
	logic y_vld_s2;
	logic [31:0] x_rd;
	logic [31:0] y_rd;
	logic [31:0] shown_x_q;
	logic [31:0] shown_y_q;
	logic [31:0] next_x;
	logic [31:0] next_y;
	logic out_free;
	logic in_acc;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free = !m_tvalid || m_tready;

	// Tracked slot count, capped at the built slot count.
	assign count = (int'(slots_q) > mst_pkg::MAX_CONTACTS) ?
		mst_pkg::cnt_t'(mst_pkg::MAX_CONTACTS) : mst_pkg::cnt_t'(slots_q);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			multi_q <= 1'b0;
			slots_q <= 5'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mst_pkg::REG_MULTI_SLOT_MODE: multi_q <= cfg_data[0];
				mst_pkg::REG_SLOTS_IN_USE: slots_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (in_acc) state_q <= ST_EXEC;
				ST_EXEC: state_q <= ST_READ;
				ST_READ: state_q <= ST_RESP;
				ST_RESP: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Input item register.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ev_q.event_type <= s_tdata[4:0];
			ev_q.event_code <= s_tdata[14:5];
			ev_q.event_value <= s_tdata[46:15];
		end
	end

	mst_decode u_decode (
		.ev(ev_q),
		.multi(multi_q),
		.count(count),
		.slot_index(slot_index_q),
		.upd(upd)
	);

	// Current slot, active flags and RAM valid bits, updated in the execute step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_index_q <= '0;
			active_q <= '0;
			x_vld_q <= '0;
			y_vld_q <= '0;
		end else if (state_q == ST_EXEC) begin
			if (upd.sel_wr) begin
				slot_index_q <= upd.sel_slot;
			end
			if (upd.act_wr) begin
				active_q[upd.act_slot] <= upd.act_val;
			end
			if (upd.clr_all) begin
				for (int i = 0; i < mst_pkg::MAX_CONTACTS; i++) begin
					if (mst_pkg::cnt_t'(i) < count) begin
						active_q[i] <= 1'b0;
					end
				end
			end
			if (upd.wr_x) begin
				x_vld_q[upd.pos_slot] <= 1'b1;
			end
			if (upd.wr_y) begin
				y_vld_q[upd.pos_slot] <= 1'b1;
			end
		end
	end

	mst_scan u_scan (
		.active(active_q),
		.count(count),
		.found(scan_found),
		.index(scan_index)
	);

	// Coordinate stores: written in the execute step, read in the scan step.
	mst_ram #(
		.WIDTH(32),
		.DEPTH(mst_pkg::MAX_CONTACTS),
		.AW(mst_pkg::SLOT_W)
	) u_x_ram (
		.clk(clk),
		.wr_en((state_q == ST_EXEC) && upd.wr_x),
		.wr_addr(upd.pos_slot),
		.wr_data(ev_q.event_value),
		.rd_en(state_q == ST_READ),
		.rd_addr(scan_index),
		.rd_data(x_rd)
	);

	mst_ram #(
		.WIDTH(32),
		.DEPTH(mst_pkg::MAX_CONTACTS),
		.AW(mst_pkg::SLOT_W)
	) u_y_ram (
		.clk(clk),
		.wr_en((state_q == ST_EXEC) && upd.wr_y),
		.wr_addr(upd.pos_slot),
		.wr_data(ev_q.event_value),
		.rd_en(state_q == ST_READ),
		.rd_addr(scan_index),
		.rd_data(y_rd)
	);

	// Scan result and valid bits, aligned with the RAM read data.
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			found_s2 <= scan_found;
			x_vld_s2 <= x_vld_q[scan_index];
			y_vld_s2 <= y_vld_q[scan_index];
		end
	end

	// An entry never written reads as zero; no active slot holds the shown position.
	assign next_x = found_s2 ? (x_vld_s2 ? x_rd : 32'd0) : shown_x_q;
	assign next_y = found_s2 ? (y_vld_s2 ? y_rd : 32'd0) : shown_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shown_x_q <= '0;
			shown_y_q <= '0;
		end else if (state_q == ST_RESP && out_free) begin
			shown_x_q <= next_x;
			shown_y_q <= next_y;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (state_q == ST_RESP && out_free) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESP && out_free) begin
			m_tdata <= {7'd0, next_y, next_x, found_s2};
		end
	end

endmodule
`default_nettype wire

// ===== bench/multitouch_slot_tracker_tb.sv =====
// Self-checking testbench for multitouch_slot_tracker: a directed table, then random event streams.
// Depends on mst_pkg and the tracker RTL; a slot store model predicts reports the table lacks.
`default_nettype none
module multitouch_slot_tracker_tb;

	// Register indexes past the two real ones; writes to them must be ignored.
	localparam logic [1:0] REG_SPARE_LO = 2'd2;
	localparam logic [1:0] REG_SPARE_HI = 2'd3;

	typedef struct packed {
		logic pressed;
		logic [31:0] x;
		logic [31:0] y;
	} report_t;

	typedef enum logic {R_EVENT, R_WRITE} step_kind_e;

	typedef struct {
		step_kind_e kind;
		logic [4:0] et;
		logic [9:0] ec;
		logic [31:0] ev;
		logic [1:0] ri;
		logic [4:0] rv;
		logic typed;
		report_t want;
	} step_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	// [4:0] event_type, [14:5] event_code, [46:15] event_value, [47] zero
	logic [47:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	// [0] pressed, [32:1] report_x, [64:33] report_y, [71:65] zero
	logic [71:0] m_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [4:0] cfg_data;

	multitouch_slot_tracker DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Local copy of the registers and the slot store.
	logic multi_cfg;
	logic [4:0] slots_cfg;
	mst_pkg::slot_t slot_sel;
	logic [31:0] pos_x [mst_pkg::MAX_CONTACTS];
	logic [31:0] pos_y [mst_pkg::MAX_CONTACTS];
	logic touch_on [mst_pkg::MAX_CONTACTS];
	logic [31:0] held_x;
	logic [31:0] held_y;

	report_t reports_due [$];
	int errors = 0;
	int reports_seen = 0;
	logic hold_req = 1'b0;
	logic sender_eager = 1'b0;

	// Applies one event to the local slot store and returns the report it causes.
	function automatic report_t track_event(input logic [4:0] et, input logic [9:0] ec,
			input logic [31:0] ev);
		int n;
		mst_pkg::slot_t cur;
		report_t r;
		n = (slots_cfg > mst_pkg::MAX_CONTACTS) ? mst_pkg::MAX_CONTACTS : int'(slots_cfg);
		cur = slot_sel;
		if (et == mst_pkg::TYPE_ABS) begin
			if (ec == mst_pkg::AX_MT_SLOT && multi_cfg) begin
				if (!ev[31] && ev < 32'(n))
					slot_sel = ev[mst_pkg::SLOT_W-1:0];
			end else if (ec == mst_pkg::AX_X) begin
				pos_x[0] = ev;
			end else if (ec == mst_pkg::AX_Y) begin
				pos_y[0] = ev;
			end else if (ec == mst_pkg::AX_MT_X) begin
				pos_x[cur] = ev;
			end else if (ec == mst_pkg::AX_MT_Y) begin
				pos_y[cur] = ev;
			end else if (ec == mst_pkg::AX_MT_ID) begin
				touch_on[cur] = !ev[31];
			end else if (ec == mst_pkg::AX_PRESSURE && !multi_cfg) begin
				touch_on[0] = !ev[31] && ev != 32'd0;
			end else if (ec == mst_pkg::AX_MT_PRESSURE && multi_cfg) begin
				if (ev == 32'd0)
					touch_on[cur] = 1'b0;
			end
		end
		if (et == mst_pkg::TYPE_KEY && ec == mst_pkg::KEY_TOUCH) begin
			if (multi_cfg) begin
				if (ev == 32'd0)
					for (int i = 0; i < n; i++)
						touch_on[i] = 1'b0;
			end else begin
				touch_on[0] = !ev[31] && ev != 32'd0;
			end
		end
		// The first active tracked slot wins; otherwise the last position is held.
		r.pressed = 1'b0;
		for (int i = 0; i < n; i++) begin
			if (!r.pressed && touch_on[i]) begin
				held_x = pos_x[i];
				held_y = pos_y[i];
				r.pressed = 1'b1;
			end
		end
		r.x = held_x;
		r.y = held_y;
		return r;
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (sender_eager || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [31:0] any_coord();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'd0;
			3, 4: return $urandom_range(0, 4095);
			default: return $urandom;
		endcase
	endfunction

	// Random event, weighted toward the multitouch protocol with some noise mixed in.
	function automatic void next_event(output logic [4:0] et, output logic [9:0] ec,
			output logic [31:0] ev);
		int pick;
		pick = $urandom_range(0, 99);
		et = mst_pkg::TYPE_ABS;
		ev = any_coord();
		if (pick < 14) begin
			ec = mst_pkg::AX_MT_SLOT;
			ev = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, slots_cfg);
		end else if (pick < 28) begin
			ec = mst_pkg::AX_MT_X;
		end else if (pick < 42) begin
			ec = mst_pkg::AX_MT_Y;
		end else if (pick < 56) begin
			ec = mst_pkg::AX_MT_ID;
			ev = ($urandom_range(0, 3) == 0) ? (32'h8000_0000 | $urandom) :
				$urandom_range(0, 65535);
		end else if (pick < 63) begin
			ec = mst_pkg::AX_MT_PRESSURE;
			ev = ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom;
		end else if (pick < 70) begin
			et = mst_pkg::TYPE_KEY;
			ec = mst_pkg::KEY_TOUCH;
			case ($urandom_range(0, 2))
				0: ev = 32'd0;
				1: ev = 32'd1;
				default: ev = $urandom;
			endcase
		end else if (pick < 74) begin
			ec = mst_pkg::AX_X;
		end else if (pick < 78) begin
			ec = mst_pkg::AX_Y;
		end else if (pick < 84) begin
			ec = mst_pkg::AX_PRESSURE;
			case ($urandom_range(0, 2))
				0: ev = 32'd0;
				1: ev = $urandom_range(1, 255);
				default: ev = $urandom;
			endcase
		end else begin
			et = 5'($urandom);
			ec = 10'($urandom_range(0, 767));
			ev = $urandom;
		end
	endfunction

	// Offers one event after a random gap; the report is predicted once the item is taken.
	task automatic offer_event(input logic [4:0] et, input logic [9:0] ec,
			input logic [31:0] ev, input logic typed, input report_t want);
		int gap;
		report_t r;
		gap = idle_len();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, ev, ec, et};
		do @(posedge clk); while (!s_tready);
		r = track_event(et, ec, ev);
		reports_due.push_back(typed ? want : r);
	endtask

	// Register writes happen only with the block drained.
	task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (reports_due.size() != 0)
			@(posedge clk);
		repeat (8) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == mst_pkg::REG_MULTI_SLOT_MODE)
			multi_cfg = val[0];
		else if (idx == mst_pkg::REG_SLOTS_IN_USE)
			slots_cfg = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Receiver: alternating ready runs and stalls, plus one long hold on request.
	initial begin
		int left;
		logic lvl;
		left = 0;
		lvl = 1'b1;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				lvl = 1'b0;
				left = 400;
			end else if (left > 0) begin
				left--;
			end else begin
				lvl = !lvl;
				if (lvl)
					left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) :
						$urandom_range(0, 20);
				else
					left = idle_len();
			end
			m_tready <= lvl;
		end
	end

	// Each report taken from the block is checked against the oldest prediction.
	always @(posedge clk) begin
		report_t want;
		report_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.pressed = m_tdata[0];
			got.x = m_tdata[32:1];
			got.y = m_tdata[64:33];
			if (reports_due.size() == 0) begin
				$display("%0t: unexpected report %0d: pressed %0b x %h y %h", $time,
					reports_seen, got.pressed, got.x, got.y);
				errors++;
			end else begin
				want = reports_due.pop_front();
				if (got.pressed !== want.pressed) begin
					$display("%0t: report %0d pressed: expected %0b, got %0b", $time,
						reports_seen, want.pressed, got.pressed);
					errors++;
				end
				if (got.x !== want.x) begin
					$display("%0t: report %0d report_x: expected %h, got %h", $time,
						reports_seen, want.x, got.x);
					errors++;
				end
				if (got.y !== want.y) begin
					$display("%0t: report %0d report_y: expected %h, got %h", $time,
						reports_seen, want.y, got.y);
					errors++;
				end
			end
			reports_seen++;
		end
	end

	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		step_t plan [$];
		logic [4:0] et;
		logic [9:0] ec;
		logic [31:0] ev;
		logic [4:0] cnt;
		logic md;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		multi_cfg = 1'b0;
		slots_cfg = 5'd1;
		slot_sel = '0;
		held_x = '0;
		held_y = '0;
		for (int i = 0; i < mst_pkg::MAX_CONTACTS; i++) begin
			pos_x[i] = '0;
			pos_y[i] = '0;
			touch_on[i] = 1'b0;
		end

		// Directed steps: single mode first, then multitouch slots and count corner cases.
		plan = '{
			'{R_EVENT, 5'd0, mst_pkg::AX_X, 32'd0, 2'd0, 5'd0, 1'b1, '{1'b0, 32'd0, 32'd0}},
			'{R_EVENT, mst_pkg::TYPE_ABS, mst_pkg::AX_X, 32'd100, 2'd0, 5'd0, 1'b1,
				'{1'b0, 32'd0, 32'd0}},
			'{R_EVENT, mst_pkg::TYPE_ABS, mst_pkg::AX_Y, 32'd200, 2'd0, 5'd0, 1'b1,
				'{1'b0, 32'd0, 32'd0}},
			'{R_EVENT, mst_pkg::TYPE_ABS, mst_pkg::AX_PRESSURE, 32'd5, 2'd0, 5'd0, 1'b1,
				'{1'b1, 32'd100, 32'd200}},
			'{R_EVENT, mst_pkg::TYPE_ABS, mst_pkg::AX_X, 32'h7FFF_FFFF, 2'd0, 5'd0, 1'b1,
				'{1'b1, 32'h7FFF_FFFF, 32'd200}},
			'{R_EVENT, mst_pkg::TYPE_ABS, mst_pkg::AX_Y, 32'h8000_0000, 2'd0, 5'd0, 1'b1,
				'{1'b1, 32'h7FFF_FFFF, 32'h8000_0000}},
			'{R_EVENT, mst_pkg::TYPE_ABS, mst_pkg::AX_PRESSURE, 32'hFFFF_FFFF, 2'd0, 5'd0,
				1'b1, '{1'b0, 32'h7FFF_FFFF, 32'h8000_0000}},
			'{R_EVENT, mst_pkg::TYPE_KEY, mst_pkg::KEY_TOUCH, 32'd1, 2'd0, 5'd0, 1'b1,
				'{1'b1, 32'h7FFF_FFFF, 32'h8000_0000}},
			'{R_EVENT, mst_pkg::TYPE_KEY, mst_pkg::KEY_TOUCH, 32'd0, 2'd0, 5'd0, 1'b1,
				'{1'b0, 32'h7FFF_FFFF, 32'h8000_0000}},
			'{R_EVENT, mst_pkg::TYPE_ABS, mst_pkg::AX_MT_SLOT, 32'd0, 2'd0, 5'd0, 1'b0, '0},
			'{R_EVENT, mst_pkg::TYPE_ABS, mst_pkg::AX_PRESSURE, 32'd0, 2'd0, 5'd0, 1'b0, '0},
			'{R_EVENT, mst_pkg::TYPE_ABS, mst_pkg::AX_MT_ID, 32'd5, 2'd0, 5'd0, 1'b0, '0},
			'{R_EVENT, mst_pkg::TYPE_ABS, mst_pkg::AX_MT_PRESSURE, 32'd0, 2'd0, 5'd0, 1'b0,
				'0},
			'{R_EVENT, 5'd31, 10'd767, 32'hFFFF_FFFF, 2'd0, 5'd0, 1'b0, '0},
			'{R_WRITE, 5'd0, mst_pkg::AX_X, 32'd0, mst_pkg::REG_MULTI_SLOT_MODE, 5'd1, 1'b0,
				'0},
			'{R_WRITE, 5'd0, mst_pkg::AX_X, 32'd0, mst_pkg::REG_SLOTS_IN_USE, 5'd16, 1'b0,
				'0},
			'{R_EVENT, mst_pkg::TYPE_ABS, mst_pkg::AX_MT_SLOT, 32'd15, 2'd0, 5'd0, 1'b0, '0},
			'{R_EVENT, mst_pkg::TYPE_ABS, mst_pkg::AX_MT_X, 32'h8000_0000, 2'd0, 5'd0, 1'b0,
				'0},
			'{R_EVENT, mst_pkg::TYPE_ABS, mst_pkg::AX_MT_Y, 32'h7FFF_FFFF, 2'd0, 5'd0, 1'b0,
				'0},
			'{R_EVENT, mst_pkg::TYPE_ABS, mst_pkg::AX_MT_ID, 32'd0, 2'd0, 5'd0, 1'b0, '0},
			'{R_EVENT, mst_pkg::TYPE_ABS, mst_pkg::AX_MT_SLOT, 32'hFFFF_FFFF, 2'd0, 5'd0, 1'b0,
				'0},
			'{R_EVENT, mst_pkg::TYPE_ABS, mst_pkg::AX_MT_SLOT, 32'd16, 2'd0, 5'd0, 1'b0, '0},
			'{R_EVENT, mst_pkg::TYPE_ABS, mst_pkg::AX_MT_SLOT, 32'd0, 2'd0, 5'd0, 1'b0, '0},
			'{R_EVENT, mst_pkg::TYPE_ABS, mst_pkg::AX_MT_PRESSURE, 32'd0, 2'd0, 5'd0, 1'b0,
				'0},
			'{R_EVENT, mst_pkg::TYPE_KEY, mst_pkg::KEY_TOUCH, 32'd1, 2'd0, 5'd0, 1'b0, '0},
			'{R_EVENT, mst_pkg::TYPE_KEY, mst_pkg::KEY_TOUCH, 32'd0, 2'd0, 5'd0, 1'b0, '0},
			'{R_EVENT, mst_pkg::TYPE_ABS, mst_pkg::AX_PRESSURE, 32'd9, 2'd0, 5'd0, 1'b0, '0},
			'{R_WRITE, 5'd0, mst_pkg::AX_X, 32'd0, mst_pkg::REG_SLOTS_IN_USE, 5'd0, 1'b0,
				'0},
			'{R_EVENT, mst_pkg::TYPE_ABS, mst_pkg::AX_MT_ID, 32'd1, 2'd0, 5'd0, 1'b0, '0},
			'{R_WRITE, 5'd0, mst_pkg::AX_X, 32'd0, mst_pkg::REG_SLOTS_IN_USE, 5'd31, 1'b0,
				'0},
			'{R_WRITE, 5'd0, mst_pkg::AX_X, 32'd0, REG_SPARE_LO, 5'd31, 1'b0, '0},
			'{R_WRITE, 5'd0, mst_pkg::AX_X, 32'd0, REG_SPARE_HI, 5'd0, 1'b0, '0},
			'{R_EVENT, mst_pkg::TYPE_ABS, mst_pkg::AX_MT_SLOT, 32'd15, 2'd0, 5'd0, 1'b0, '0},
			'{R_WRITE, 5'd0, mst_pkg::AX_X, 32'd0, mst_pkg::REG_SLOTS_IN_USE, 5'd4, 1'b0,
				'0},
			'{R_EVENT, mst_pkg::TYPE_ABS, mst_pkg::AX_MT_ID, 32'd2, 2'd0, 5'd0, 1'b0, '0}
		};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			if (plan[i].kind == R_WRITE)
				write_reg(plan[i].ri, plan[i].rv);
			else
				offer_event(plan[i].et, plan[i].ec, plan[i].ev, plan[i].typed, plan[i].want);
		end

		// Random phases, each under its own register setting.
		for (int ph = 0; ph < 12; ph++) begin
			if (ph < 2)
				md = 1'b1;
			else if (ph == 2)
				md = 1'b0;
			else
				md = ($urandom_range(0, 3) != 0);
			if (ph == 0) begin
				cnt = 5'd16;
			end else if (ph == 1) begin
				cnt = 5'd1;
			end else if ($urandom_range(0, 4) == 0) begin
				case ($urandom_range(0, 3))
					0: cnt = 5'd0;
					1: cnt = 5'd16;
					2: cnt = 5'd17;
					default: cnt = 5'd31;
				endcase
			end else begin
				cnt = 5'($urandom_range(1, 16));
			end
			write_reg(mst_pkg::REG_MULTI_SLOT_MODE, {4'($urandom), md});
			write_reg(mst_pkg::REG_SLOTS_IN_USE, cnt);
			if ($urandom_range(0, 3) == 0)
				write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_LO : REG_SPARE_HI,
					5'($urandom));
			sender_eager = (ph % 4 == 1);
			// One long receiver hold while events keep coming, so the input backs up.
			if (ph == 3)
				hold_req = 1'b1;
			for (int k = 0; k < 90; k++) begin
				next_event(et, ec, ev);
				offer_event(et, ec, ev, 1'b0, '0);
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (reports_due.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
`default_nettype wire

// ===== multitouch_slot_tracker.f =====
design/mst_pkg.sv
design/mst_ram.sv
design/mst_decode.sv
design/mst_scan.sv
design/multitouch_slot_tracker.sv
bench/multitouch_slot_tracker_tb.sv
